// ----- rtl/pwt_pkg.sv -----
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and constants for the protobuf wire field tokenizer: result
// kinds, end status codes, length width and the record that the front part
// hands to the back part through the queue.
// ----------------------------------------------------------------------------
package pwt_pkg;

  // Width of a length-delimited field's length; longer ones flag truncation.
  localparam int LENGTH_BITS = 32;

  // Records between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_FIXED32 = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LENGTH  = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_MALF    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Everything one input byte causes: at most one field result and one
  // message-end result.
  typedef struct packed {
    logic        dat_v;
    logic [2:0]  kind;
    logic [31:0] field_id;
    logic [2:0]  wire_code;
    logic [63:0] field_value;
    logic        end_v;
    logic [1:0]  end_status;
  } rec_t;

endpackage

// ----- rtl/pwt_front.sv -----
// ----------------------------------------------------------------------------
// pwt_front
// Accepts message bytes, runs the key/value/length/payload decoder and pushes
// one record per byte that causes any result.
// ----------------------------------------------------------------------------
module pwt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  logic [31:0]         required_field,
  input  logic                q_full,
  output logic                q_push,
  output pwt_pkg::rec_t       q_rec
);

  typedef enum logic [2:0] {
    PH_KEY,
    PH_VALUE,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [63:0]                     acc_r, acc_nxt;
  logic [3:0]                      idx_r, idx_nxt;
  logic [31:0]                     field_r, field_nxt;
  logic [2:0]                      wire_r, wire_nxt;
  logic [pwt_pkg::LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                            seen_r, seen_nxt;
  logic [1:0]                      err_r, err_nxt;

  logic                            accept;
  logic [1:0]                      errc;
  logic [6:0]                      sh7;
  logic [63:0]                     vacc;
  logic [63:0]                     facc;
  logic [pwt_pkg::LENGTH_BITS-1:0] rem_dec;
  pwt_pkg::rec_t                   rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign errc     = in_last_byte ? pwt_pkg::ST_TRUNC : pwt_pkg::ST_MALF;
  assign sh7      = {idx_r, 3'b000} - {3'b000, idx_r};
  assign vacc     = acc_r | (64'(in_data_byte[6:0]) << sh7);
  assign facc     = acc_r | (64'(in_data_byte) << {idx_r[2:0], 3'b000});
  assign rem_dec  = (rem_r == '0) ? rem_r : rem_r - pwt_pkg::LENGTH_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    field_nxt = field_r;
    wire_nxt  = wire_r;
    rem_nxt   = rem_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    rec       = '0;

    unique case (phase_r)
      PH_KEY, PH_VALUE, PH_LENGTH: begin
        if (idx_r >= 4'd9 && in_data_byte[7:1] != 7'd0) begin
          err_nxt   = errc;
          phase_nxt = PH_ERROR;
          acc_nxt   = '0;
          idx_nxt   = '0;
        end else if (in_data_byte[7]) begin
          acc_nxt = vacc;
          idx_nxt = idx_r + 4'd1;
        end else begin
          acc_nxt = '0;
          idx_nxt = '0;
          if (phase_r == PH_KEY) begin
            if (vacc[63:3] == 61'd0 || vacc[63:35] != 29'd0) begin
              err_nxt   = errc;
              phase_nxt = PH_ERROR;
            end else begin
              field_nxt = vacc[34:3];
              wire_nxt  = vacc[2:0];
              if (required_field != 32'd0 && vacc[34:3] == required_field) begin
                seen_nxt = 1'b1;
              end
              unique case (vacc[2:0])
                pwt_pkg::WIRE_VARINT:  phase_nxt = PH_VALUE;
                pwt_pkg::WIRE_FIXED64: begin
                  phase_nxt = PH_FIXED;
                  rem_nxt   = pwt_pkg::LENGTH_BITS'(8);
                end
                pwt_pkg::WIRE_LENGTH:  phase_nxt = PH_LENGTH;
                pwt_pkg::WIRE_FIXED32: begin
                  phase_nxt = PH_FIXED;
                  rem_nxt   = pwt_pkg::LENGTH_BITS'(4);
                end
                default: begin
                  err_nxt   = errc;
                  phase_nxt = PH_ERROR;
                end
              endcase
            end
          end else if (phase_r == PH_VALUE) begin
            rec.dat_v       = 1'b1;
            rec.kind        = pwt_pkg::KIND_VARINT;
            rec.field_id    = field_r;
            rec.wire_code   = pwt_pkg::WIRE_VARINT;
            rec.field_value = vacc;
            phase_nxt       = PH_KEY;
          end else if ((vacc >> pwt_pkg::LENGTH_BITS) != 64'd0) begin
            // A length no message can satisfy counts as truncation.
            err_nxt   = pwt_pkg::ST_TRUNC;
            phase_nxt = PH_ERROR;
          end else begin
            rec.dat_v       = 1'b1;
            rec.kind        = pwt_pkg::KIND_LENGTH;
            rec.field_id    = field_r;
            rec.wire_code   = pwt_pkg::WIRE_LENGTH;
            rec.field_value = vacc;
            rem_nxt         = vacc[pwt_pkg::LENGTH_BITS-1:0];
            phase_nxt       = (vacc == 64'd0) ? PH_KEY : PH_PAYLOAD;
          end
        end
      end
      PH_FIXED: begin
        acc_nxt = facc;
        idx_nxt = idx_r + 4'd1;
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          rec.dat_v       = 1'b1;
          rec.kind        = (wire_r == pwt_pkg::WIRE_FIXED64) ? pwt_pkg::KIND_FIXED64
                                                            : pwt_pkg::KIND_FIXED32;
          rec.field_id    = field_r;
          rec.wire_code   = wire_r;
          rec.field_value = facc;
          acc_nxt         = '0;
          idx_nxt         = '0;
          phase_nxt       = PH_KEY;
        end
      end
      PH_PAYLOAD: begin
        rec.dat_v       = 1'b1;
        rec.kind        = pwt_pkg::KIND_PAYLOAD;
        rec.field_id    = field_r;
        rec.wire_code   = pwt_pkg::WIRE_LENGTH;
        rec.field_value = 64'(in_data_byte);
        rem_nxt         = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_KEY;
        end
      end
      PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (in_last_byte) begin
      rec.end_v = 1'b1;
      if (err_nxt != pwt_pkg::ST_OK) begin
        rec.end_status = err_nxt;
      end else if (phase_nxt != PH_KEY || idx_nxt != 4'd0) begin
        rec.end_status = pwt_pkg::ST_TRUNC;
      end else if (required_field != 32'd0 && !seen_nxt) begin
        rec.end_status = pwt_pkg::ST_MISSING;
      end else begin
        rec.end_status = pwt_pkg::ST_OK;
      end
      // The next message starts from a clean decoder.
      phase_nxt = PH_KEY;
      acc_nxt   = '0;
      idx_nxt   = '0;
      field_nxt = '0;
      wire_nxt  = '0;
      rem_nxt   = '0;
      seen_nxt  = 1'b0;
      err_nxt   = pwt_pkg::ST_OK;
    end
  end

  assign q_push = accept && (rec.dat_v || rec.end_v);
  assign q_rec  = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      acc_r   <= '0;
      idx_r   <= '0;
      field_r <= '0;
      wire_r  <= '0;
      rem_r   <= '0;
      seen_r  <= 1'b0;
      err_r   <= pwt_pkg::ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
      field_r <= field_nxt;
      wire_r  <= wire_nxt;
      rem_r   <= rem_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- rtl/pwt_fifo.sv -----
// ----------------------------------------------------------------------------
// pwt_fifo
// Short record queue between the decoder front and the result back end.
// ----------------------------------------------------------------------------
module pwt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pwt_pkg::rec_t push_rec,
  input  logic          pop,
  output pwt_pkg::rec_t head,
  output logic          empty,
  output logic          full
);

  pwt_pkg::rec_t               mem_r [pwt_pkg::QDEPTH];
  logic [pwt_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [pwt_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [pwt_pkg::QPTR_W:0]    count_r, count_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (pwt_pkg::QPTR_W + 1)'(pwt_pkg::QDEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (pwt_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (pwt_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + pwt_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pwt_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/pwt_back.sv -----
// ----------------------------------------------------------------------------
// pwt_back
// Unpacks queued records into result beats, one per cycle while not stalled,
// held in an output register until the consumer takes them.
// ----------------------------------------------------------------------------
module pwt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pwt_pkg::rec_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_kind,
  output logic [31:0]   out_field_id,
  output logic [2:0]    out_wire_code,
  output logic [63:0]   out_field_value,
  output logic [1:0]    out_end_status,
  output logic          out_last_of_run
);

  logic        valid_r;
  logic        sub_r, sub_nxt;
  logic [2:0]  kind_r;
  logic [31:0] field_r;
  logic [2:0]  wire_r;
  logic [63:0] value_r;
  logic [1:0]  status_r;
  logic        last_r;

  logic        load;
  logic        take_data;

  // A record's field result goes out first; sub_r marks it as already sent.
  assign load      = !q_empty && (!valid_r || !out_stall);
  assign take_data = head.dat_v && !sub_r;
  assign q_pop     = load && !(take_data && head.end_v);
  assign sub_nxt   = take_data && head.end_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      sub_r   <= sub_nxt;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_data) begin
        kind_r   <= head.kind;
        field_r  <= head.field_id;
        wire_r   <= head.wire_code;
        value_r  <= head.field_value;
        status_r <= pwt_pkg::ST_OK;
        last_r   <= !head.end_v;
      end else begin
        kind_r   <= pwt_pkg::KIND_END;
        field_r  <= '0;
        wire_r   <= '0;
        value_r  <= '0;
        status_r <= head.end_status;
        last_r   <= 1'b1;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_field_id    = field_r;
  assign out_wire_code   = wire_r;
  assign out_field_value = value_r;
  assign out_end_status  = status_r;
  assign out_last_of_run = last_r;

endmodule

// ----- rtl/protobuf_wire_field_tokenizer.sv -----
// Results go through the record queue and the output register before they appear.
// Throughput: one byte per cycle while in_stall is low; a byte that yields a field
// result and message end makes two beats, absorbed by the queue and output register.
// Reset: synchronous, active low; clears the decoder, the queue, the output valid
// and the required field register to zero.
// ----------------------------------------------------------------------------
// protobuf_wire_field_tokenizer
// Protobuf wire-format tokenizer: splits keys into field number and wire type
// and emits varint, fixed, length and payload results plus a message status.
// ----------------------------------------------------------------------------
module protobuf_wire_field_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_field_id,
  output logic [2:0]  out_wire_code,
  output logic [63:0] out_field_value,
  output logic [1:0]  out_end_status,
  output logic        out_last_of_run
);

  logic [31:0]   required_field_r;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  pwt_pkg::rec_t q_rec;
  pwt_pkg::rec_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      required_field_r <= '0;
    end else if (cfg_wr_en) begin
      required_field_r <= cfg_wr_data;
    end
  end

  pwt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .required_field (required_field_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_rec)
  );

  pwt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pwt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_field_id    (out_field_id),
    .out_wire_code   (out_wire_code),
    .out_field_value (out_field_value),
    .out_end_status  (out_end_status),
    .out_last_of_run (out_last_of_run)
  );

  // The queue never takes a record it has no room for.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // The second beat of a run is already queued when the first one is shown.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid)
    else $error("run ended without its last beat");

  // Only the message-end beat carries a status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != pwt_pkg::KIND_END |-> out_end_status == pwt_pkg::ST_OK)
    else $error("status on a field beat");

  // A message-end beat always closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == pwt_pkg::KIND_END |-> out_last_of_run)
    else $error("message end not last of run");

endmodule

// ----- tb/sv/protobuf_wire_field_tokenizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protobuf_wire_field_tokenizer_tb
// Self-checking bench for the wire field tokenizer. Encoded messages, both
// well formed and broken, are pushed in byte by byte; a software copy of the
// decoder predicts every token and status, and each output beat is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module protobuf_wire_field_tokenizer_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - pwt_pkg::LENGTH_BITS);

  typedef enum logic [2:0] {
    DEC_KEY, DEC_VALUE, DEC_FIXED, DEC_LENGTH, DEC_PAYLOAD, DEC_ERROR
  } dec_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] field_id;
    logic [2:0]  wire_code;
    logic [63:0] field_value;
    logic [1:0]  end_status;
    logic        last_of_run;
  } token_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_field_id;
  logic [2:0]  out_wire_code;
  logic [63:0] out_field_value;
  logic [1:0]  out_end_status;
  logic        out_last_of_run;

  protobuf_wire_field_tokenizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_field_id    (out_field_id),
    .out_wire_code   (out_wire_code),
    .out_field_value (out_field_value),
    .out_end_status  (out_end_status),
    .out_last_of_run (out_last_of_run)
  );

  // Decoder copy used for prediction.
  logic [31:0] required_field_cfg = '0;
  dec_phase_t  dec_phase;
  logic [63:0] dec_acc;
  logic [3:0]  dec_index;
  logic [31:0] dec_field;
  logic [2:0]  dec_wire;
  logic [63:0] dec_bytes_left;
  logic        dec_required_seen;
  logic [1:0]  dec_error;

  token_t      expected_tokens[$];
  logic [7:0]  msg_bytes[$];
  int          live_bytes = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          rx_hold_req = 0;
  int          rx_hold_left = 0;
  int          rx_wait_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void clear_decoder();
    dec_phase = DEC_KEY;
    dec_acc = '0;
    dec_index = '0;
    dec_field = '0;
    dec_wire = '0;
    dec_bytes_left = '0;
    dec_required_seen = 1'b0;
    dec_error = pwt_pkg::ST_OK;
  endfunction

  function automatic void enter_error(input logic [1:0] code);
    dec_error = code;
    dec_phase = DEC_ERROR;
    dec_acc = '0;
    dec_index = '0;
  endfunction

  function automatic token_t make_token(input logic [2:0] kind, input logic [31:0] field,
                                        input logic [2:0] wcode, input logic [63:0] value,
                                        input logic [1:0] status);
    token_t t;
    t.kind = kind;
    t.field_id = field;
    t.wire_code = wcode;
    t.field_value = value;
    t.end_status = status;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  // Advances the decoder copy by one byte and queues the tokens it yields.
  function automatic void tokenize_byte(input logic [7:0] b, input logic last);
    token_t      produced[$];
    logic [1:0]  errc;
    logic [1:0]  status;
    logic [63:0] v;
    logic [63:0] f;
    errc = last ? pwt_pkg::ST_TRUNC : pwt_pkg::ST_MALF;
    if (dec_phase != DEC_ERROR) live_bytes++;
    case (dec_phase)
      DEC_KEY, DEC_VALUE, DEC_LENGTH: begin
        if (dec_index >= 9 && b[7:1] != 0) begin
          enter_error(errc);
        end else begin
          dec_acc |= {57'd0, b[6:0]} << (7 * dec_index);
          if (b[7]) begin
            dec_index++;
          end else begin
            v = dec_acc;
            dec_acc = '0;
            dec_index = '0;
            if (dec_phase == DEC_KEY) begin
              f = v >> 3;
              if (v == 0 || f == 0 || f > 64'hffff_ffff) begin
                enter_error(errc);
              end else begin
                dec_field = f[31:0];
                dec_wire = v[2:0];
                if (required_field_cfg != 0 && dec_field == required_field_cfg)
                  dec_required_seen = 1'b1;
                case (v[2:0])
                  pwt_pkg::WIRE_VARINT: dec_phase = DEC_VALUE;
                  pwt_pkg::WIRE_FIXED64: begin
                    dec_phase = DEC_FIXED;
                    dec_bytes_left = 8;
                  end
                  pwt_pkg::WIRE_LENGTH: dec_phase = DEC_LENGTH;
                  pwt_pkg::WIRE_FIXED32: begin
                    dec_phase = DEC_FIXED;
                    dec_bytes_left = 4;
                  end
                  default: enter_error(errc);
                endcase
              end
            end else if (dec_phase == DEC_VALUE) begin
              produced.push_back(make_token(pwt_pkg::KIND_VARINT, dec_field,
                                            pwt_pkg::WIRE_VARINT, v, pwt_pkg::ST_OK));
              dec_phase = DEC_KEY;
            end else if (v > LEN_MAX) begin
              // A length no message can hold is flagged at once, without a header.
              enter_error(pwt_pkg::ST_TRUNC);
            end else begin
              produced.push_back(make_token(pwt_pkg::KIND_LENGTH, dec_field,
                                            pwt_pkg::WIRE_LENGTH, v, pwt_pkg::ST_OK));
              dec_bytes_left = v;
              dec_phase = (v == 0) ? DEC_KEY : DEC_PAYLOAD;
            end
          end
        end
      end
      DEC_FIXED: begin
        dec_acc |= {56'd0, b} << (8 * dec_index[2:0]);
        dec_index++;
        if (dec_bytes_left != 0) dec_bytes_left--;
        if (dec_bytes_left == 0) begin
          produced.push_back(make_token((dec_wire == pwt_pkg::WIRE_FIXED64) ?
                                        pwt_pkg::KIND_FIXED64 : pwt_pkg::KIND_FIXED32,
                                        dec_field, dec_wire, dec_acc, pwt_pkg::ST_OK));
          dec_acc = '0;
          dec_index = '0;
          dec_phase = DEC_KEY;
        end
      end
      DEC_PAYLOAD: begin
        produced.push_back(make_token(pwt_pkg::KIND_PAYLOAD, dec_field, pwt_pkg::WIRE_LENGTH,
                                      {56'd0, b}, pwt_pkg::ST_OK));
        if (dec_bytes_left != 0) dec_bytes_left--;
        if (dec_bytes_left == 0) dec_phase = DEC_KEY;
      end
      default: ;
    endcase
    if (last) begin
      if (dec_error != pwt_pkg::ST_OK) status = dec_error;
      else if (dec_phase != DEC_KEY || dec_index != 0) status = pwt_pkg::ST_TRUNC;
      else if (required_field_cfg != 0 && !dec_required_seen) status = pwt_pkg::ST_MISSING;
      else status = pwt_pkg::ST_OK;
      produced.push_back(make_token(pwt_pkg::KIND_END, '0, '0, '0, status));
      clear_decoder();
    end
    if (produced.size() > 0) produced[produced.size() - 1].last_of_run = 1'b1;
    foreach (produced[i]) expected_tokens.push_back(produced[i]);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Output beats are checked before input beats are predicted; a result never
  // leaves in the same cycle its byte is taken.
  always @(posedge clk) begin
    token_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d field %0d",
                                    out_kind, out_field_id));
        end else begin
          want = expected_tokens.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
          if (out_field_id !== want.field_id)
            report_mismatch($sformatf("field_id %0d, expected %0d",
                                      out_field_id, want.field_id));
          if (out_wire_code !== want.wire_code)
            report_mismatch($sformatf("wire_code %0d, expected %0d",
                                      out_wire_code, want.wire_code));
          if (out_field_value !== want.field_value)
            report_mismatch($sformatf("field_value %0h, expected %0h",
                                      out_field_value, want.field_value));
          if (out_end_status !== want.end_status)
            report_mismatch($sformatf("end_status %0d, expected %0d",
                                      out_end_status, want.end_status));
          if (out_last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                      out_last_of_run, want.last_of_run));
        end
      end
      if (in_valid && !in_stall) tokenize_byte(in_data_byte, in_last_byte);
    end
  end

  // Result side: a random wait after each beat, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_wait_left = rx_calm ? 0 : $urandom_range(0, 11);
      out_stall <= (rx_wait_left != 0);
    end else if (rx_wait_left != 0) begin
      rx_wait_left--;
      out_stall <= (rx_wait_left != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= value;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic write_required(input logic [31:0] value);
    wait_all_results();
    // Key and continuation bytes leave nothing queued, so give the block a moment.
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    required_field_cfg = value;
  endtask

  // Encoders for building messages.
  function automatic int draw_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic void add_varint(input logic [63:0] v, input int pad);
    int          nbytes;
    logic [63:0] rest;
    nbytes = 1;
    rest = v >> 7;
    while (rest != 0) begin
      nbytes++;
      rest = rest >> 7;
    end
    nbytes += pad;
    if (nbytes > 10) nbytes = 10;
    for (int i = 0; i < nbytes; i++) begin
      rest = v >> (7 * i);
      msg_bytes.push_back({i < nbytes - 1, rest[6:0]});
    end
  endfunction

  function automatic void add_key(input logic [31:0] field, input logic [2:0] wcode);
    add_varint(({32'd0, field} << 3) | {61'd0, wcode}, draw_pad());
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    int          nbits;
    v = {$urandom, $urandom};
    nbits = $urandom_range(0, 64);
    if (nbits == 64 && $urandom_range(0, 1) == 1) v = {64{1'b1}};
    else if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
    return v;
  endfunction

  function automatic logic [31:0] pick_field();
    logic [31:0] f;
    case ($urandom_range(0, 9))
      0: f = (required_field_cfg != 0) ? required_field_cfg : 32'd1;
      1: f = 32'hffff_ffff;
      2: f = $urandom;
      default: f = $urandom_range(1, 20);
    endcase
    return (f == 0) ? 32'd1 : f;
  endfunction

  function automatic void add_field();
    logic [31:0] field;
    logic [2:0]  wcode;
    int          len;
    field = pick_field();
    case ($urandom_range(0, 3))
      0: wcode = pwt_pkg::WIRE_VARINT;
      1: wcode = pwt_pkg::WIRE_FIXED64;
      2: wcode = pwt_pkg::WIRE_LENGTH;
      default: wcode = pwt_pkg::WIRE_FIXED32;
    endcase
    add_key(field, wcode);
    case (wcode)
      pwt_pkg::WIRE_VARINT: add_varint(rand_wide(), draw_pad());
      pwt_pkg::WIRE_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
      pwt_pkg::WIRE_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
      default: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
        add_varint(64'(len), draw_pad());
        repeat (len) msg_bytes.push_back(8'($urandom));
      end
    endcase
  endfunction

  // Mostly complete messages; the rest end early or carry a broken key,
  // varint or length, sometimes with junk after the error.
  function automatic void build_random_message();
    int mode;
    int drop;
    int w;
    msg_bytes.delete();
    if ($urandom_range(0, 11) == 0) begin
      add_noise();
      return;
    end
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3))
      add_field();
    mode = $urandom_range(0, 9);
    if (mode >= 6 && mode < 8) begin
      drop = $urandom_range(1, 4);
      while (drop > 0 && msg_bytes.size() > 1) begin
        void'(msg_bytes.pop_back());
        drop--;
      end
    end else if (mode >= 8) begin
      case ($urandom_range(0, 6))
        0: begin
          w = $urandom_range(0, 3);
          add_key($urandom_range(1, 40), (w < 2) ? 3'(3 + w) : 3'(4 + w));
        end
        1: add_varint(64'd0, draw_pad());
        2: msg_bytes.push_back(8'($urandom_range(1, 7)));
        3: add_varint({$urandom, $urandom} | (64'd1 << $urandom_range(35, 63)), 0);
        4: begin
          case ($urandom_range(0, 2))
            1: add_key(pick_field(), pwt_pkg::WIRE_VARINT);
            2: add_key(pick_field(), pwt_pkg::WIRE_LENGTH);
            default: ;
          endcase
          repeat (9) msg_bytes.push_back(8'h80 | 8'($urandom));
          msg_bytes.push_back(8'($urandom_range(2, 255)));
        end
        5: begin
          add_key(pick_field(), pwt_pkg::WIRE_LENGTH);
          add_varint({$urandom, $urandom} | (64'd1 << $urandom_range(32, 63)), draw_pad());
        end
        default: add_noise();
      endcase
      if ($urandom_range(0, 1) == 1) add_noise();
    end
  endfunction

  task automatic test_directed_cases();
    msg_bytes = '{8'h08, 8'h00};
    send_message();
    // A zero key on the final byte reports truncated rather than malformed.
    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'h0b, 8'hff};
    send_message();
    msg_bytes = '{8'h01, 8'h00};
    send_message();
    msg_bytes = '{8'h0d, 8'h01, 8'h02, 8'h03, 8'hfe, 8'h12, 8'h01, 8'haa};
    send_message();
    msg_bytes = '{8'h12, 8'h00, 8'h1a};
    send_message();
    write_required(32'd5);
    msg_bytes = '{8'h08, 8'h96, 8'h01};
    send_message();
    msg_bytes = '{8'h28, 8'h01};
    send_message();
    wait_all_results();
  endtask

  // Receiver holds off while the sender streams back to back, so the
  // internal queue fills and the input side has to stall. The first message
  // carries a long payload so that every byte after its key yields a beat.
  task automatic test_output_backpressure();
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    rx_hold_req = 80;
    msg_bytes.delete();
    msg_bytes.push_back(8'h0a);
    msg_bytes.push_back(8'h10);
    repeat (16) msg_bytes.push_back(8'($urandom));
    send_message();
    repeat (3) begin
      build_random_message();
      send_message();
    end
    wait_all_results();
    tx_calm = 1'b0;
  endtask

  task automatic test_random_messages(input logic [31:0] required, input int n_bytes);
    int start;
    write_required(required);
    start = live_bytes;
    while (live_bytes - start < n_bytes) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      build_random_message();
      send_message();
      if ($urandom_range(0, 7) == 0) wait_all_results();
    end
    wait_all_results();
  endtask

  initial begin
    clear_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_output_backpressure();
    test_random_messages(32'd0, 200);
    test_random_messages(32'hffff_ffff, 150);
    test_random_messages(32'd3, 150);
    test_random_messages($urandom, 100);
    test_random_messages(32'd1, 100);
    wait_all_results();
    rx_calm = 1'b1;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
